// File: rtl/http_chunked_body_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// http chunked body decoder assertion macros
// Shared property forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CHBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chbd check failed");

// next-cycle implication, off during reset
`define CHBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chbd check failed");

`endif

// File: rtl/chbd_pkg.sv
// ----------------------------------------------------------------------------
// chbd_pkg
// Types and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package chbd_pkg;

    // decoder phases
    typedef enum logic [3:0] {
        PH_SIZE       = 4'd0,
        PH_EXT        = 4'd1,
        PH_SIZE_LF    = 4'd2,
        PH_DATA       = 4'd3,
        PH_DATA_LF    = 4'd4,
        PH_TRAILER    = 4'd5,
        PH_TRAILER_LF = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERROR      = 4'd8
    } phase_t;

    // result status codes
    localparam logic [2:0] ST_FRAME    = 3'd0;
    localparam logic [2:0] ST_PAYLOAD  = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_ERR      = 3'd3;
    localparam logic [2:0] ST_LEFTOVER = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    // framing characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classified request from the front
    typedef struct packed {
        logic       start;
        logic       is_hex;
        logic [3:0] hex_digit;
        logic       is_cr;
        logic       is_lf;
        logic [7:0] byte_value;
    } item_t;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/http_chunked_body_decoder_top.sv
// a result passes through a queue entry register and then the result register
// one byte per cycle while the queue has room, bounded by the single framing state update per cycle
// the two-entry request queue absorbs output stalls until it fills, then in_ready drops
// reset: rst_n clears phase, size, count, queue and output valid; start_req clears
// the framing state in front of the byte that carries it
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Classifies each byte of an HTTP chunked body as framing, payload, end,
// error, leftover or ignored.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       start_req,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] data_byte
);

    chbd_pkg::item_t         wr_item;
    chbd_pkg::item_t         rd_item;
    chbd_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    // byte classification and input accept
    chbd_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .start_req  (start_req),
        .q_status   (q_status),
        .push       (push),
        .item       (wr_item)
    );

    // decoupling queue
    chbd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (wr_item),
        .pop      (pop),
        .rd_item  (rd_item),
        .q_status (q_status)
    );

    // framing state machine and result register
    chbd_back
    #(
        .SIZE_BITS (SIZE_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (rd_item),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data_byte (data_byte)
    );

endmodule

// File: rtl/chbd_front.sv
// ----------------------------------------------------------------------------
// chbd_front
// Accepts input requests and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module chbd_front
(
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             byte_value,
    input  logic                   start_req,
    input  chbd_pkg::queue_status_t q_status,
    output logic                   push,
    output chbd_pkg::item_t        item
);

    // accept whenever the queue has room
    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // byte classification
    always_comb
    begin
        item.start      = start_req;
        item.byte_value = byte_value;
        item.is_cr      = (byte_value == chbd_pkg::CH_CR);
        item.is_lf      = (byte_value == chbd_pkg::CH_LF);
        item.is_hex     = 1'b0;
        item.hex_digit  = byte_value[3:0];
        if (byte_value inside {[8'h30:8'h39]})
        begin
            item.is_hex = 1'b1;
        end
        else if (byte_value inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            // letters a..f map from low nibble 1..6
            item.is_hex    = 1'b1;
            item.hex_digit = byte_value[3:0] + 4'd9;
        end
    end

endmodule

// File: rtl/chbd_queue.sv
// ----------------------------------------------------------------------------
// chbd_queue
// Small register queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module chbd_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  chbd_pkg::item_t         wr_item,
    input  logic                    pop,
    output chbd_pkg::item_t         rd_item,
    output chbd_pkg::queue_status_t q_status
);

    localparam int PTR_W = chbd_pkg::QUEUE_PTR_W;
    localparam int CNT_W = chbd_pkg::QUEUE_CNT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(chbd_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(chbd_pkg::QUEUE_DEPTH);

    chbd_pkg::item_t  entry_reg [chbd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign rd_item        = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/chbd_back.sv
// ----------------------------------------------------------------------------
// chbd_back
// Framing state machine and output register of the chunked body decoder.
// ----------------------------------------------------------------------------
module chbd_back
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  chbd_pkg::item_t         item,
    input  chbd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              status,
    output logic [7:0]              data_byte
);

    chbd_pkg::phase_t     phase_reg, phase_next, cur_phase;
    logic [SIZE_BITS-1:0] len_reg, len_next, cur_len;
    logic [SIZE_BITS-1:0] seen_reg, seen_next, cur_seen;
    logic                 tline_reg, tline_next, cur_tline;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           status_reg, status_next;
    logic [7:0]           data_reg;
    logic                 size_full;
    logic                 more_data;

    // take the next request when the output slot is free or draining
    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    // start request clears state ahead of this byte
    always_comb
    begin
        if (item.start)
        begin
            cur_phase = chbd_pkg::PH_SIZE;
            cur_len   = '0;
            cur_seen  = '0;
            cur_tline = 1'b0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_len   = len_reg;
            cur_seen  = seen_reg;
            cur_tline = tline_reg;
        end
    end

    assign size_full = (cur_len[SIZE_BITS-1 -: 4] != 4'd0);
    assign more_data = (cur_seen < cur_len);

    // next state
    always_comb
    begin
        phase_next = cur_phase;
        len_next   = cur_len;
        seen_next  = cur_seen;
        tline_next = cur_tline;
        case (cur_phase)
            chbd_pkg::PH_SIZE:
            begin
                if (item.is_hex)
                begin
                    if (size_full)
                    begin
                        phase_next = chbd_pkg::PH_ERROR;
                    end
                    else
                    begin
                        len_next = {cur_len[SIZE_BITS-5:0], item.hex_digit};
                    end
                end
                else if (item.is_cr)
                begin
                    phase_next = chbd_pkg::PH_SIZE_LF;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_EXT;
                end
            end
            chbd_pkg::PH_EXT:
            begin
                if (item.is_cr)
                begin
                    phase_next = chbd_pkg::PH_SIZE_LF;
                end
            end
            chbd_pkg::PH_SIZE_LF:
            begin
                if (!item.is_lf)
                begin
                    phase_next = chbd_pkg::PH_ERROR;
                end
                else if (cur_len != '0)
                begin
                    phase_next = chbd_pkg::PH_DATA;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_TRAILER;
                    tline_next = 1'b0;
                end
            end
            chbd_pkg::PH_DATA:
            begin
                if (more_data)
                begin
                    seen_next = cur_seen + 1'b1;
                end
                else if (item.is_cr)
                begin
                    phase_next = chbd_pkg::PH_DATA_LF;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_ERROR;
                end
            end
            chbd_pkg::PH_DATA_LF:
            begin
                if (item.is_lf)
                begin
                    len_next   = '0;
                    seen_next  = '0;
                    phase_next = chbd_pkg::PH_SIZE;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_ERROR;
                end
            end
            chbd_pkg::PH_TRAILER:
            begin
                if (item.is_cr)
                begin
                    phase_next = chbd_pkg::PH_TRAILER_LF;
                end
                else
                begin
                    tline_next = 1'b1;
                end
            end
            chbd_pkg::PH_TRAILER_LF:
            begin
                if (!item.is_lf)
                begin
                    phase_next = chbd_pkg::PH_ERROR;
                end
                else if (cur_tline)
                begin
                    phase_next = chbd_pkg::PH_TRAILER;
                    tline_next = 1'b0;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // result status
    always_comb
    begin
        status_next = chbd_pkg::ST_FRAME;
        case (cur_phase)
            chbd_pkg::PH_SIZE:
            begin
                if (item.is_hex && size_full)
                begin
                    status_next = chbd_pkg::ST_ERR;
                end
            end
            chbd_pkg::PH_EXT:
            begin
                status_next = chbd_pkg::ST_FRAME;
            end
            chbd_pkg::PH_SIZE_LF:
            begin
                if (!item.is_lf)
                begin
                    status_next = chbd_pkg::ST_ERR;
                end
            end
            chbd_pkg::PH_DATA:
            begin
                if (more_data)
                begin
                    status_next = chbd_pkg::ST_PAYLOAD;
                end
                else if (!item.is_cr)
                begin
                    status_next = chbd_pkg::ST_ERR;
                end
            end
            chbd_pkg::PH_DATA_LF, chbd_pkg::PH_TRAILER_LF:
            begin
                if (!item.is_lf)
                begin
                    status_next = chbd_pkg::ST_ERR;
                end
                else if (cur_phase == chbd_pkg::PH_TRAILER_LF && !cur_tline)
                begin
                    status_next = chbd_pkg::ST_COMPLETE;
                end
            end
            chbd_pkg::PH_TRAILER:
            begin
                status_next = chbd_pkg::ST_FRAME;
            end
            chbd_pkg::PH_DONE:
            begin
                status_next = chbd_pkg::ST_LEFTOVER;
            end
            default:
            begin
                status_next = chbd_pkg::ST_IGNORED;
            end
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= chbd_pkg::PH_SIZE;
            len_reg       <= '0;
            seen_reg      <= '0;
            tline_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
                tline_reg <= tline_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            data_reg   <= item.byte_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_byte = data_reg;

endmodule

// File: rtl/chbd_checker.sv
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_top_macros.svh"

module chbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [7:0] data_byte
);

    // a stalled result stays
    `CHBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // a stalled result keeps its payload
    `CHBD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(status) && $stable(data_byte))

    // status codes stay within the defined set
    `CHBD_ASSERT_IMPLY(a_status_range, clk, rst_n, out_valid, status <= chbd_pkg::ST_IGNORED)

    // input back-pressure only while a result is held
    `CHBD_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, out_valid)

endmodule

bind http_chunked_body_decoder_top chbd_checker u_chbd_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the chunked body decoder one byte at a time. A local decoder
// predicts the status of every accepted byte, and each result leaving the
// block is compared with the oldest prediction. Traffic is mostly well-formed
// bodies with random content, some corrupted, plus random noise bytes.
// ----------------------------------------------------------------------------
module tb;

    localparam int SIZE_BITS    = 32;
    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [4:0] NOT_HEX = 5'd16;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [2:0] status;
        logic [7:0] data;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] byte_value;
    logic       start_req;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] status;
    logic [7:0] data_byte;

    // decoder state mirrored by the testbench
    chbd_pkg::phase_t     dec_phase;
    logic [SIZE_BITS-1:0] dec_size;
    logic [SIZE_BITS-1:0] dec_seen;
    logic                 dec_trailer_nonempty;

    result_t pending_results[$];
    int      error_count;
    int      bytes_sent;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_req;
    int      hold_seen;
    int      hold_left;

    http_chunked_body_decoder_top #(.SIZE_BITS(SIZE_BITS)) u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data_byte  (data_byte)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t run limit reached with %0d results pending",
                     $time, pending_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(negedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: status %0d data %h",
                         $time, status, data_byte);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t status mismatch: expected %0d got %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (data_byte !== want.data)
                begin
                    $display("%0t data_byte mismatch: expected %h got %h",
                             $time, want.data, data_byte);
                    error_count++;
                end
            end
        end
    end

    // hex digit value, NOT_HEX for anything else
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return {1'b0, 4'(b - "0")};
        if (b >= "a" && b <= "f")
            return {1'b0, 4'(b - "a" + 8'd10)};
        if (b >= "A" && b <= "F")
            return {1'b0, 4'(b - "A" + 8'd10)};
        return NOT_HEX;
    endfunction

    // predicted status of one accepted byte, updates the mirrored state
    task automatic decode_byte(input logic [7:0] b, input logic s, output logic [2:0] st);
        logic [4:0] nib;
        nib = hex_nibble(b);
        st = chbd_pkg::ST_FRAME;
        if (s)
        begin
            dec_phase = chbd_pkg::PH_SIZE;
            dec_size = '0;
            dec_seen = '0;
            dec_trailer_nonempty = 1'b0;
        end
        case (dec_phase)
            chbd_pkg::PH_SIZE:
            begin
                if (nib != NOT_HEX)
                begin
                    // one more digit must not push bits past the top
                    if (dec_size[SIZE_BITS-1 -: 4] != 4'h0)
                    begin
                        dec_phase = chbd_pkg::PH_ERROR;
                        st = chbd_pkg::ST_ERR;
                    end
                    else
                    begin
                        dec_size = {dec_size[SIZE_BITS-5:0], nib[3:0]};
                    end
                end
                else if (b == chbd_pkg::CH_CR)
                    dec_phase = chbd_pkg::PH_SIZE_LF;
                else
                    dec_phase = chbd_pkg::PH_EXT;
            end
            chbd_pkg::PH_EXT:
            begin
                if (b == chbd_pkg::CH_CR)
                    dec_phase = chbd_pkg::PH_SIZE_LF;
            end
            chbd_pkg::PH_SIZE_LF:
            begin
                if (b != chbd_pkg::CH_LF)
                begin
                    dec_phase = chbd_pkg::PH_ERROR;
                    st = chbd_pkg::ST_ERR;
                end
                else if (dec_size != '0)
                    dec_phase = chbd_pkg::PH_DATA;
                else
                begin
                    dec_phase = chbd_pkg::PH_TRAILER;
                    dec_trailer_nonempty = 1'b0;
                end
            end
            chbd_pkg::PH_DATA:
            begin
                if (dec_seen < dec_size)
                begin
                    dec_seen++;
                    st = chbd_pkg::ST_PAYLOAD;
                end
                else if (b == chbd_pkg::CH_CR)
                    dec_phase = chbd_pkg::PH_DATA_LF;
                else
                begin
                    dec_phase = chbd_pkg::PH_ERROR;
                    st = chbd_pkg::ST_ERR;
                end
            end
            chbd_pkg::PH_DATA_LF:
            begin
                if (b == chbd_pkg::CH_LF)
                begin
                    dec_size = '0;
                    dec_seen = '0;
                    dec_phase = chbd_pkg::PH_SIZE;
                end
                else
                begin
                    dec_phase = chbd_pkg::PH_ERROR;
                    st = chbd_pkg::ST_ERR;
                end
            end
            chbd_pkg::PH_TRAILER:
            begin
                if (b == chbd_pkg::CH_CR)
                    dec_phase = chbd_pkg::PH_TRAILER_LF;
                else
                    dec_trailer_nonempty = 1'b1;
            end
            chbd_pkg::PH_TRAILER_LF:
            begin
                if (b != chbd_pkg::CH_LF)
                begin
                    dec_phase = chbd_pkg::PH_ERROR;
                    st = chbd_pkg::ST_ERR;
                end
                else if (dec_trailer_nonempty)
                begin
                    dec_phase = chbd_pkg::PH_TRAILER;
                    dec_trailer_nonempty = 1'b0;
                end
                else
                begin
                    dec_phase = chbd_pkg::PH_DONE;
                    st = chbd_pkg::ST_COMPLETE;
                end
            end
            chbd_pkg::PH_DONE:
                st = chbd_pkg::ST_LEFTOVER;
            default:
                st = chbd_pkg::ST_IGNORED;
        endcase
    endtask

    // offer one request and wait until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic s);
        logic       taken;
        logic [2:0] st;
        result_t    r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        start_req  <= s;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        decode_byte(b, s, st);
        r.status = st;
        r.data = b;
        pending_results.push_back(r);
        bytes_sent++;
    endtask

    // a byte sequence, start_req on its first byte
    task automatic send_seq(input byte_q_t seq);
        int i;
        for (i = 0; i < seq.size(); i++)
            send_byte(seq[i], i == 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        if (d < 4'd10)
            return "0" + {4'h0, d};
        return (upper ? "A" : "a") + {4'h0, d} - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_cr();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == chbd_pkg::CH_CR) ? "x" : b;
    endfunction

    // optional chunk extension, never containing CR
    function automatic byte_q_t ext_bytes();
        byte_q_t e;
        int      j;
        int      n;
        if ($urandom_range(99) < 30)
        begin
            e.push_back(";");
            n = $urandom_range(5);
            for (j = 0; j < n; j++)
                e.push_back(rand_non_cr());
        end
        return e;
    endfunction

    // a chunked body with random sizes, content, trailers and leftover,
    // sometimes with one byte corrupted
    function automatic byte_q_t build_body();
        byte_q_t     seq;
        int          n_chunks;
        int          len;
        int          nd;
        int          n;
        int          i;
        int          j;
        logic [3:0]  digs[8];
        logic [31:0] tmp;
        n_chunks = $urandom_range(3);
        for (i = 0; i < n_chunks; i++)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
            n = $urandom_range(2);
            for (j = 0; j < n; j++)
                seq.push_back("0");
            tmp = len;
            nd = 0;
            while (tmp != 0)
            begin
                digs[nd] = tmp[3:0];
                tmp = tmp >> 4;
                nd++;
            end
            for (j = nd - 1; j >= 0; j--)
                seq.push_back(hex_char(digs[j], 1'($urandom_range(1))));
            seq = {seq, ext_bytes()};
            seq.push_back(chbd_pkg::CH_CR);
            seq.push_back(chbd_pkg::CH_LF);
            for (j = 0; j < len; j++)
                seq.push_back(8'($urandom_range(255)));
            seq.push_back(chbd_pkg::CH_CR);
            seq.push_back(chbd_pkg::CH_LF);
        end
        // last chunk, sometimes with no digits at all
        nd = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
        for (j = 0; j < nd; j++)
            seq.push_back("0");
        seq = {seq, ext_bytes()};
        seq.push_back(chbd_pkg::CH_CR);
        seq.push_back(chbd_pkg::CH_LF);
        // trailer lines, then the empty line
        n_chunks = $urandom_range(2);
        for (i = 0; i < n_chunks; i++)
        begin
            n = $urandom_range(6, 1);
            for (j = 0; j < n; j++)
                seq.push_back(rand_non_cr());
            seq.push_back(chbd_pkg::CH_CR);
            seq.push_back(chbd_pkg::CH_LF);
        end
        seq.push_back(chbd_pkg::CH_CR);
        seq.push_back(chbd_pkg::CH_LF);
        // leftover after the end
        n = $urandom_range(3);
        for (j = 0; j < n; j++)
            seq.push_back(8'($urandom_range(255)));
        // corruption
        if ($urandom_range(99) < 15)
            seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
        return seq;
    endfunction

    // minimal body with extension, zero payload byte, leftover 0xff
    task automatic test_directed_framing();
        byte_q_t seq;
        seq = '{"1", chbd_pkg::CH_CR, chbd_pkg::CH_LF, 8'h00,
                chbd_pkg::CH_CR, chbd_pkg::CH_LF,
                "0", ";", "e", chbd_pkg::CH_CR, chbd_pkg::CH_LF,
                chbd_pkg::CH_CR, chbd_pkg::CH_LF, 8'hFF};
        send_seq(seq);
    endtask

    // size overflow then an ignored byte; CR as first non-hex byte then missing LF
    task automatic test_overflow_and_errors();
        byte_q_t seq;
        seq = '{"f", "f", "F", "f", "F", "f", "f", "f", "0", 8'h00};
        send_seq(seq);
        seq = '{chbd_pkg::CH_CR, "G", chbd_pkg::CH_LF};
        send_seq(seq);
    endtask

    // receiver holds off while bodies keep coming, so the input stalls
    task automatic test_input_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= hold_req + 1;
        for (i = 0; i < 3; i++)
            send_seq(build_body());
    endtask

    // mostly well-formed bodies, with noise bytes and stray start flags
    task automatic test_random_traffic(input int n_bytes, input int send_pct,
                                       input int recv_pct);
        int target;
        int n;
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                n = $urandom_range(6, 1);
                for (k = 0; k < n; k++)
                    send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
            else
            begin
                send_seq(build_body());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        byte_value = 8'h00;
        start_req = 1'b0;
        out_ready = 1'b0;
        error_count = 0;
        bytes_sent = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        dec_phase = chbd_pkg::PH_SIZE;
        dec_size = '0;
        dec_seen = '0;
        dec_trailer_nonempty = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_framing();
        test_overflow_and_errors();
        test_input_backpressure();
        test_random_traffic(320, 7, 84);
        test_random_traffic(320, 84, 7);
        test_random_traffic(320, 0, 0);

        // drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: http_chunked_body_decoder_top.f
+incdir+rtl
rtl/chbd_pkg.sv
rtl/chbd_front.sv
rtl/chbd_queue.sv
rtl/chbd_back.sv
rtl/http_chunked_body_decoder_top.sv
rtl/chbd_checker.sv
tb/tb.sv
